/* src/assert_macros.svh */
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* src/csri_pkg.sv */
// Types and constants of the comment stripper and re-indenter.
package csri_pkg;

  localparam int MAX_DEPTH_DEF = 255;
  localparam int LEVEL_W = 13;
  localparam int FIFO_DEPTH = 2;

  localparam logic [3:0] INDENT_WIDTH_RST = 4'd4;
  localparam logic REG_IDX_INDENT_WIDTH = 1'b0;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef logic signed [LEVEL_W-1:0] level_t;

  typedef struct packed {
    logic slash;
    logic indent_en;
    level_t level;
    logic char_valid;
    logic [7:0] char_byte;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* src/csri_fifo.sv */
// Short queue of classified transactions between the front and back parts.
module csri_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  csri_pkg::token_t   push_data,
  input  logic               pop,
  output csri_pkg::token_t   pop_data,
  output csri_pkg::q_status_t status
);

  localparam int AW = $clog2(csri_pkg::FIFO_DEPTH);

  csri_pkg::token_t entries [csri_pkg::FIFO_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(csri_pkg::FIFO_DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(csri_pkg::FIFO_DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  assign pop_data = entries[rptr];
  assign status.full = (count == (AW+1)'(csri_pkg::FIFO_DEPTH));
  assign status.empty = (count == '0);

endmodule

/* src/csri_front.sv */
// Front part: tracks comment, line start and brace depth and classifies each byte.
module csri_front #(
  parameter int MAX_DEPTH = csri_pkg::MAX_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       in_char,
  output csri_pkg::token_t token
);

  localparam int DW = $clog2(MAX_DEPTH + 1) + 1;
  localparam logic signed [DW-1:0] DEPTH_HI = DW'(MAX_DEPTH);
  localparam logic signed [DW-1:0] DEPTH_LO = -DW'(MAX_DEPTH);

  logic in_comment;
  logic in_comment_next;
  logic [7:0] last_char;
  logic [7:0] last_char_next;
  logic signed [DW-1:0] depth;
  logic signed [DW-1:0] depth_next;
  csri_pkg::level_t depth_ext;

  assign depth_ext = csri_pkg::LEVEL_W'(depth);

  always_comb begin
    in_comment_next = in_comment;
    last_char_next = last_char;
    depth_next = depth;
    token = '0;
    if (in_comment) begin
      if (in_char == csri_pkg::CH_NEWLINE) begin
        in_comment_next = 1'b0;
        last_char_next = csri_pkg::CH_NEWLINE;
        token.char_valid = 1'b1;
        token.char_byte = csri_pkg::CH_NEWLINE;
      end
    end else if (last_char == csri_pkg::CH_SLASH && in_char == csri_pkg::CH_SLASH) begin
      in_comment_next = 1'b1;
    end else if (!(last_char == csri_pkg::CH_NEWLINE &&
                   (in_char == csri_pkg::CH_SPACE || in_char == csri_pkg::CH_TAB))) begin
      token.slash = (last_char == csri_pkg::CH_SLASH);
      token.indent_en = (last_char == csri_pkg::CH_NEWLINE);
      token.level = (in_char == csri_pkg::CH_RBRACE) ?
                    depth_ext - csri_pkg::LEVEL_W'(1) : depth_ext;
      if (in_char == csri_pkg::CH_LBRACE && depth < DEPTH_HI) begin
        depth_next = depth + DW'(1);
      end else if (in_char == csri_pkg::CH_RBRACE && depth > DEPTH_LO) begin
        depth_next = depth - DW'(1);
      end
      if (in_char != csri_pkg::CH_SLASH) begin
        token.char_valid = 1'b1;
        token.char_byte = in_char;
      end
      last_char_next = in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_comment <= 1'b0;
      last_char <= '0;
      depth <= '0;
    end else if (take) begin
      in_comment <= in_comment_next;
      last_char <= last_char_next;
      depth <= depth_next;
    end
  end

endmodule

/* src/csri_back.sv */
// Back part: turns a classified transaction into the indent count and holds the result.
module csri_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [3:0]       indent_width,
  input  logic             q_valid,
  input  csri_pkg::token_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             slash_out,
  output logic [11:0]      indent_count,
  output logic             char_valid,
  output logic [7:0]       char_out
);

  localparam int PW = (csri_pkg::LEVEL_W + 3 > 12) ? csri_pkg::LEVEL_W + 3 : 12;

  logic [PW-1:0] product;
  logic [11:0] indent_calc;

  assign product = PW'(q_data.level[csri_pkg::LEVEL_W-2:0]) * PW'(indent_width);

  always_comb begin
    if (!q_data.indent_en || q_data.level <= csri_pkg::level_t'(0)) begin
      indent_calc = '0;
    end else if (product > PW'(12'hFFF)) begin
      indent_calc = 12'hFFF;
    end else begin
      indent_calc = product[11:0];
    end
  end

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      slash_out <= q_data.slash;
      indent_count <= indent_calc;
      char_valid <= q_data.char_valid;
      char_out <= q_data.char_byte;
    end
  end

endmodule

/* src/comment_strip_reindent.sv */
// Top level of the streaming comment stripper and re-indenter.
// Takes one source byte per transaction and gives one result per byte: a released slash, an
// indent count and an optional byte. A new byte is accepted every clock cycle unless in_stall
// is high because the queue is full; the result passes through the queue and the output
// register on its way to the outputs. The rate is set by the front part, whose comment,
// previous-byte and brace-depth registers are updated once per accepted byte, and the
// two-entry queue before the output register lets either side stall on its own.
`include "assert_macros.svh"
module comment_strip_reindent #(
  parameter int MAX_DEPTH = csri_pkg::MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        slash_out,
  output logic [11:0] indent_count,
  output logic        char_valid,
  output logic [7:0]  char_out
);

  logic [3:0] indent_width;
  logic take;
  logic q_pop;
  csri_pkg::token_t token;
  csri_pkg::token_t q_data;
  csri_pkg::q_status_t q_status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      indent_width <= csri_pkg::INDENT_WIDTH_RST;
    end else if (psel && penable && pwrite && paddr[2] == csri_pkg::REG_IDX_INDENT_WIDTH) begin
      indent_width <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == csri_pkg::REG_IDX_INDENT_WIDTH) ? {28'd0, indent_width} : '0;

  assign in_stall = q_status.full;
  assign take = in_valid && !in_stall;

  csri_front #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .take(take),
    .in_char(in_char),
    .token(token)
  );

  csri_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(take),
    .push_data(token),
    .pop(q_pop),
    .pop_data(q_data),
    .status(q_status)
  );

  csri_back u_back (
    .clk(clk),
    .rst(rst),
    .indent_width(indent_width),
    .q_valid(!q_status.empty),
    .q_data(q_data),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .slash_out(slash_out),
    .indent_count(indent_count),
    .char_valid(char_valid),
    .char_out(char_out)
  );

  `ASSERT_NEXT(a_push_lands, clk, rst, take, !q_status.empty, "Accepted transaction missing from queue")
  `ASSERT_NEXT(a_queue_drains, clk, rst, !q_status.empty && (!out_valid || !out_stall), out_valid, "Queued transaction not moved to output")
  `ASSERT_IMPLY(a_slash_no_indent, clk, rst, out_valid && slash_out, indent_count == 12'd0, "Slash released together with an indent")

endmodule
